// ===== design/xoo_pkg.sv =====
// Shared types, constants and helpers for the Xoodoo-384 permutation block.
// No dependencies; imported by the round unit and the top level.
`default_nettype none

package xoo_pkg;

	localparam int unsigned LANE_W     = 32;
	localparam int unsigned LANE_COUNT = 12;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned MAX_ROUNDS = 12;

	typedef logic [LANE_W-1:0] lane_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [LANE_COUNT-1:0][LANE_W-1:0] state_t;

	localparam idx_t LAST_IDX   = idx_t'(LANE_COUNT - 1);
	localparam idx_t MAX_RND    = idx_t'(MAX_ROUNDS);
	localparam idx_t LAST_ROUND = idx_t'(MAX_ROUNDS - 1);

	// Left rotation by a constant amount between 1 and 31.
	function automatic lane_t rotl(lane_t v, int unsigned r);
		return (v << r) | (v >> (LANE_W - r));
	endfunction

	// Round constant for a table position.
	function automatic lane_t round_const(idx_t idx);
		lane_t rc;
		case (idx)
			4'd0:    rc = 32'h0000_0058;
			4'd1:    rc = 32'h0000_0038;
			4'd2:    rc = 32'h0000_03C0;
			4'd3:    rc = 32'h0000_00D0;
			4'd4:    rc = 32'h0000_0120;
			4'd5:    rc = 32'h0000_0014;
			4'd6:    rc = 32'h0000_0060;
			4'd7:    rc = 32'h0000_002C;
			4'd8:    rc = 32'h0000_0380;
			4'd9:    rc = 32'h0000_00F0;
			4'd10:   rc = 32'h0000_01A0;
			4'd11:   rc = 32'h0000_0012;
			default: rc = '0;
		endcase
		return rc;
	endfunction

endpackage

`default_nettype wire

// ===== design/xoodoo_permutation.sv =====
// Top level of the Xoodoo-384 permutation: lane shift register, round sequencer
// and output stream. Depends on xoo_pkg and xoo_round.
`default_nettype none

// Lanes are taken one per cycle while busy is low, lane 0 first. The twelfth
// lane raises busy; the block then runs the configured number of rounds
// through one round unit, one round per cycle, and streams the twelve lanes
// out on consecutive cycles, each marked by lane_strobe for exactly one cycle,
// with last_lane on lane 11. The receiver cannot stall the stream. num_rounds
// above 12 acts as 12, and 0 passes the state through unchanged; it may be
// written whenever no state is in flight.
module xoodoo_permutation (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire  xoo_pkg::lane_t lane_in,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  xoo_pkg::idx_t  cfg_data,
	output logic                 lane_strobe,
	output xoo_pkg::lane_t       lane_out,
	output xoo_pkg::idx_t        lane_index,
	output logic                 last_lane
);
	import xoo_pkg::*;

	localparam logic [1:0] PH_LOAD  = 2'd0;
	localparam logic [1:0] PH_ROUND = 2'd1;
	localparam logic [1:0] PH_EMIT  = 2'd2;

	logic [1:0] phase_q;
	idx_t       count_q;
	idx_t       round_q;
	idx_t       num_rounds_q;
	state_t     lanes_q;
	state_t     round_out;
	idx_t       rounds_eff;
	logic       accept;

	xoo_round u_round (
		.state_in  (lanes_q),
		.rc        (round_const(round_q)),
		.state_out (round_out)
	);

	assign accept     = start && !busy;
	assign busy       = (phase_q != PH_LOAD);
	assign cfg_ready  = 1'b1;
	assign rounds_eff = (num_rounds_q > MAX_RND) ? MAX_RND : num_rounds_q;

	assign lane_strobe = (phase_q == PH_EMIT);
	assign lane_out    = lanes_q[0];
	assign lane_index  = count_q;
	assign last_lane   = (phase_q == PH_EMIT) && (count_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LOAD;
			count_q      <= '0;
			round_q      <= '0;
			num_rounds_q <= MAX_RND;
		end else begin
			if (cfg_valid && cfg_ready) begin
				num_rounds_q <= cfg_data;
			end
			case (phase_q)
				PH_LOAD: begin
					if (accept) begin
						if (count_q == LAST_IDX) begin
							count_q <= '0;
							round_q <= MAX_RND - rounds_eff;
							phase_q <= (rounds_eff == '0) ? PH_EMIT : PH_ROUND;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				PH_ROUND: begin
					if (round_q == LAST_ROUND) begin
						round_q <= '0;
						phase_q <= PH_EMIT;
					end else begin
						round_q <= round_q + 1'b1;
					end
				end
				PH_EMIT: begin
					if (count_q == LAST_IDX) begin
						count_q <= '0;
						phase_q <= PH_LOAD;
					end else begin
						count_q <= count_q + 1'b1;
					end
				end
				default: begin
					phase_q <= PH_LOAD;
					count_q <= '0;
					round_q <= '0;
				end
			endcase
		end
	end

	// Lanes shift toward position 0 both when loading and when streaming out,
	// so the first lane loaded ends up at position 0.
	always_ff @(posedge clk) begin
		if ((phase_q == PH_LOAD && accept) || phase_q == PH_EMIT) begin
			for (int i = 0; i < LANE_COUNT - 1; i++) begin
				lanes_q[i] <= lanes_q[i+1];
			end
			lanes_q[LANE_COUNT-1] <= lane_in;
		end else if (phase_q == PH_ROUND) begin
			lanes_q <= round_out;
		end
	end

endmodule

`default_nettype wire

// ===== design/xoo_round.sv =====
// One Xoodoo round as combinational logic: theta, rho-west, iota, chi, rho-east.
// Depends on xoo_pkg for the state type and the rotate helper.
`default_nettype none

module xoo_round (
	input  wire  xoo_pkg::state_t state_in,
	input  wire  xoo_pkg::lane_t  rc,
	output xoo_pkg::state_t       state_out
);
	import xoo_pkg::*;

	lane_t  p [4];
	lane_t  e [4];
	state_t a;
	state_t w;
	state_t c;

	always_comb begin
		for (int x = 0; x < 4; x++) begin
			p[x] = state_in[x] ^ state_in[4+x] ^ state_in[8+x];
		end
		for (int x = 0; x < 4; x++) begin
			e[x] = rotl(p[(x+3)%4], 5) ^ rotl(p[(x+3)%4], 14);
		end
		for (int x = 0; x < 4; x++) begin
			a[x]   = state_in[x]   ^ e[x];
			a[4+x] = state_in[4+x] ^ e[x];
			a[8+x] = state_in[8+x] ^ e[x];
		end
		for (int x = 0; x < 4; x++) begin
			w[x]   = a[x];
			w[4+x] = a[4+((x+3)%4)];
			w[8+x] = rotl(a[8+x], 11);
		end
		w[0] = w[0] ^ rc;
		for (int x = 0; x < 4; x++) begin
			c[x]   = w[x]   ^ (~w[4+x] & w[8+x]);
			c[4+x] = w[4+x] ^ (~w[8+x] & w[x]);
			c[8+x] = w[8+x] ^ (~w[x]   & w[4+x]);
		end
		for (int x = 0; x < 4; x++) begin
			state_out[x]   = c[x];
			state_out[4+x] = rotl(c[4+x], 1);
			state_out[8+x] = rotl(c[8+((x+2)%4)], 8);
		end
	end

endmodule

`default_nettype wire

// ===== sim/xoodoo_checker.sv =====
// Checker for the Xoodoo-384 permutation: watches the lane, config and result
// channels, predicts the permuted lanes and compares them in order.
// Depends on xoo_pkg for the lane and index types.
module xoodoo_checker (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire                  busy,
	input  wire  xoo_pkg::lane_t lane_in,
	input  wire                  cfg_valid,
	input  wire                  cfg_ready,
	input  wire  xoo_pkg::idx_t  cfg_data,
	input  wire                  lane_strobe,
	input  wire  xoo_pkg::lane_t lane_out,
	input  wire  xoo_pkg::idx_t  lane_index,
	input  wire                  last_lane,
	output int                   fail_count,
	output int                   pending_lanes
);
	timeunit 1ns;
	timeprecision 1ps;

	import xoo_pkg::*;

	typedef struct packed {
		lane_t lane;
		idx_t  idx;
		logic  last;
	} lane_result_t;

	localparam lane_t IOTA_CONSTS [0:11] = '{
		32'h0000_0058, 32'h0000_0038, 32'h0000_03C0, 32'h0000_00D0,
		32'h0000_0120, 32'h0000_0014, 32'h0000_0060, 32'h0000_002C,
		32'h0000_0380, 32'h0000_00F0, 32'h0000_01A0, 32'h0000_0012
	};

	lane_result_t lanes_due[$];
	lane_result_t oldest;
	state_t       gathered;
	state_t       permuted;
	int           lanes_loaded;
	idx_t         rounds_cfg;

	function automatic lane_t rol32(lane_t v, int unsigned r);
		return (v << r) | (v >> (32 - r));
	endfunction

	function automatic state_t perm_round(state_t a, lane_t rc);
		lane_t  parity [4];
		lane_t  effect [4];
		state_t b;
		// theta: each column takes the rotated parity of its western neighbor
		for (int x = 0; x < 4; x++) begin
			parity[x] = a[x] ^ a[4 + x] ^ a[8 + x];
		end
		for (int x = 0; x < 4; x++) begin
			effect[x] = rol32(parity[(x + 3) % 4], 5) ^ rol32(parity[(x + 3) % 4], 14);
		end
		for (int i = 0; i < 12; i++) begin
			a[i] = a[i] ^ effect[i % 4];
		end
		for (int x = 0; x < 4; x++) begin
			b[x]     = a[x];
			b[4 + x] = a[4 + (x + 3) % 4];
			b[8 + x] = rol32(a[8 + x], 11);
		end
		b[0] = b[0] ^ rc;
		for (int x = 0; x < 4; x++) begin
			a[x]     = b[x] ^ (~b[4 + x] & b[8 + x]);
			a[4 + x] = b[4 + x] ^ (~b[8 + x] & b[x]);
			a[8 + x] = b[8 + x] ^ (~b[x] & b[4 + x]);
		end
		for (int x = 0; x < 4; x++) begin
			b[x]     = a[x];
			b[4 + x] = rol32(a[4 + x], 1);
			b[8 + x] = rol32(a[8 + (x + 2) % 4], 8);
		end
		return b;
	endfunction

	// Applies the last rounds of the table; counts above twelve act as twelve.
	function automatic state_t xoodoo_permute(state_t s, idx_t rounds);
		int n;
		n = (rounds > 12) ? 12 : int'(rounds);
		for (int r = 12 - n; r < 12; r++) begin
			s = perm_round(s, IOTA_CONSTS[r]);
		end
		return s;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t ns: lane mismatch: %s", $time, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending_lanes = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_due.delete();
			lanes_loaded = 0;
			rounds_cfg = 4'd12;
			gathered = '0;
			pending_lanes = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				rounds_cfg = cfg_data;
			end
			if (lane_strobe) begin
				if (lanes_due.size() == 0) begin
					report_mismatch($sformatf("unexpected lane %0d = %h", lane_index, lane_out));
				end else begin
					oldest = lanes_due.pop_front();
					if (lane_out !== oldest.lane) begin
						report_mismatch($sformatf("lane %0d value %h, expected %h",
							oldest.idx, lane_out, oldest.lane));
					end
					if (lane_index !== oldest.idx) begin
						report_mismatch($sformatf("index %0d, expected %0d",
							lane_index, oldest.idx));
					end
					if (last_lane !== oldest.last) begin
						report_mismatch($sformatf("last flag %b on lane %0d, expected %b",
							last_lane, oldest.idx, oldest.last));
					end
				end
			end
			if (start && !busy) begin
				gathered[lanes_loaded] = lane_in;
				lanes_loaded++;
				if (lanes_loaded == 12) begin
					permuted = xoodoo_permute(gathered, rounds_cfg);
					for (int i = 0; i < 12; i++) begin
						lanes_due.push_back('{permuted[i], idx_t'(i), i == 11});
					end
					lanes_loaded = 0;
				end
			end
			pending_lanes = lanes_due.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// Top of the Xoodoo-384 permutation testbench: clock, reset, lane and round
// count stimulus, watchdog and verdict. Depends on xoo_pkg, xoodoo_checker
// and the design.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import xoo_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int END_CYCLES     = 30;
	localparam int RANDOM_STATES  = 19;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	lane_t lane_in = '0;
	logic  cfg_valid = 1'b0;
	idx_t  cfg_data = '0;
	logic  busy;
	logic  cfg_ready;
	logic  lane_strobe;
	lane_t lane_out;
	idx_t  lane_index;
	logic  last_lane;
	int    fail_count;
	int    pending_lanes;
	int    quiet_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	xoodoo_permutation DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.lane_in     (lane_in),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.lane_strobe (lane_strobe),
		.lane_out    (lane_out),
		.lane_index  (lane_index),
		.last_lane   (last_lane)
	);

	xoodoo_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.lane_in       (lane_in),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.lane_strobe   (lane_strobe),
		.lane_out      (lane_out),
		.lane_index    (lane_index),
		.last_lane     (last_lane),
		.fail_count    (fail_count),
		.pending_lanes (pending_lanes)
	);

	// Any handshake on any channel resets the count of dead cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || (cfg_valid && cfg_ready) || lane_strobe) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("** xoodoo_permutation: FAILED **");
				$finish;
			end
		end
	end

	task automatic send_lane(lane_t v);
		start <= 1'b1;
		lane_in <= v;
		do @(posedge clk); while (busy);
	endtask

	task automatic sender_pause();
		start <= 1'b0;
		repeat ($urandom_range(1, 19)) @(posedge clk);
	endtask

	task automatic send_state(state_t s, bit gaps);
		for (int i = 0; i < 12; i++) begin
			send_lane(s[i]);
			if (gaps && $urandom_range(0, 4) == 0) begin
				sender_pause();
			end
		end
	endtask

	// Holds the sender until every predicted lane has been emitted.
	task automatic drain_results();
		start <= 1'b0;
		@(negedge clk);
		while (pending_lanes != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_rounds(idx_t n);
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic lane_t pick_lane();
		lane_t v;
		case ($urandom_range(0, 9))
			0:       v = '0;
			1:       v = '1;
			2:       v = lane_t'(1) << $urandom_range(0, 31);
			3:       v = ~(lane_t'(1) << $urandom_range(0, 31));
			default: v = $urandom;
		endcase
		return v;
	endfunction

	initial begin
		state_t lanes;
		idx_t   rounds;
		bit     reconfigure;
		bit     tail;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero state under the reset round count of twelve.
		lanes = '0;
		send_state(lanes, 1'b0);

		// Zero rounds: the lanes must come back unchanged.
		drain_results();
		write_rounds(4'd0);
		for (int i = 0; i < 12; i++) begin
			case (i % 4)
				0:       lanes[i] = '1;
				1:       lanes[i] = 32'hAAAA_AAAA;
				2:       lanes[i] = 32'h8000_0001;
				default: lanes[i] = 32'h5555_5555;
			endcase
		end
		send_state(lanes, 1'b1);

		for (int s = 0; s < RANDOM_STATES; s++) begin
			tail = (s >= RANDOM_STATES - 3);
			reconfigure = 1'b1;
			case (s)
				0:       rounds = 4'd1;
				3:       rounds = 4'd15;
				6:       rounds = 4'd13;
				9:       rounds = 4'd12;
				12:      rounds = 4'd0;
				default: begin
					rounds = idx_t'($urandom_range(0, 15));
					reconfigure = !tail && ($urandom_range(0, 3) == 0);
				end
			endcase
			if (reconfigure) begin
				drain_results();
				write_rounds(rounds);
			end else if (!tail && $urandom_range(0, 5) == 0) begin
				drain_results();
			end
			for (int i = 0; i < 12; i++) begin
				lanes[i] = pick_lane();
			end
			send_state(lanes, !tail && $urandom_range(0, 2) != 0);
		end

		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_lanes == 0) begin
			$display("** xoodoo_permutation: PASSED **");
		end else begin
			$display("** xoodoo_permutation: FAILED **");
		end
		$finish;
	end

endmodule

// ===== xoodoo_permutation.f =====
design/xoo_pkg.sv
design/xoo_round.sv
design/xoodoo_permutation.sv
sim/xoodoo_checker.sv
sim/tb_top.sv
